FILE: rtl/qrs_pkg.sv
// shared types, constants and gf(256) helpers for the qr reed-solomon parity encoder
package qrs_pkg;

  // largest degree the qr standard uses for one block
  localparam int ECC_LIMIT   = 30;
  localparam int MAX_ECC_DEF = 30;
  localparam int ECC_MIN     = 2;
  localparam int ECC_RESET   = 10;

  // field polynomial x^8+x^4+x^3+x^2+1
  localparam logic [8:0] FIELD_POLY = 9'h11D;

  // generator table: row = degree, column = coefficient (column 0 is the leading one)
  typedef logic [ECC_LIMIT:0][ECC_LIMIT:0][7:0] gen_tab_t;

  // gf(256) multiply, shift and add
  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [8:0] x;
    logic [7:0] r;
    x = {1'b0, a};
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = r ^ x[7:0];
      x = {x[7:0], 1'b0};
      if (x[8]) x = x ^ FIELD_POLY;
    end
    return r;
  endfunction

  // product of (x + alpha^i) for every degree, worked out at elaboration
  function automatic gen_tab_t build_gen_tab();
    gen_tab_t   t;
    logic [7:0] root;
    t = '0;
    for (int n = 0; n <= ECC_LIMIT; n++) begin
      t[n][0] = 8'h01;
      root    = 8'h01;
      for (int i = 0; i < n; i++) begin
        for (int j = i + 1; j >= 1; j--) begin
          t[n][j] = t[n][j] ^ gf_mul(t[n][j-1], root);
        end
        root = gf_mul(root, 8'h02);
      end
    end
    return t;
  endfunction

  localparam gen_tab_t GEN_TAB = build_gen_tab();

endpackage

FILE: rtl/qrs_cfg.sv
// degree register with clamping and generator coefficient row
module qrs_cfg #(
  parameter int MAX_ECC = qrs_pkg::MAX_ECC_DEF,
  localparam int CAP   = (MAX_ECC < qrs_pkg::ECC_LIMIT) ? MAX_ECC : qrs_pkg::ECC_LIMIT,
  localparam int CNT_W = $clog2(CAP + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [4:0]              cfg_ecc_count,
  output logic [CNT_W-1:0]        ecc_n,
  output logic [CAP-1:0][7:0]     gen_coef
);

  localparam int RST_DEG = (qrs_pkg::ECC_RESET > CAP) ? CAP : qrs_pkg::ECC_RESET;

  logic [CNT_W-1:0]    ecc_n_r, ecc_n_nxt;
  logic [CAP-1:0][7:0] gen_r, gen_nxt;

  // clamp the written degree and pick its generator row
  always_comb begin
    int v;
    v = int'(cfg_ecc_count);
    if (v < qrs_pkg::ECC_MIN) v = qrs_pkg::ECC_MIN;
    if (v > CAP) v = CAP;
    ecc_n_nxt = CNT_W'(v);
    for (int j = 0; j < CAP; j++) begin
      gen_nxt[j] = qrs_pkg::GEN_TAB[5'(v)][j+1];
    end
  end

  // degree and coefficients, loaded on a write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ecc_n_r <= CNT_W'(RST_DEG);
      for (int j = 0; j < CAP; j++) begin
        gen_r[j] <= qrs_pkg::GEN_TAB[RST_DEG][j+1];
      end
    end else if (cfg_wr_en) begin
      ecc_n_r <= ecc_n_nxt;
      gen_r   <= gen_nxt;
    end
  end

  assign ecc_n    = ecc_n_r;
  assign gen_coef = gen_r;

endmodule

FILE: rtl/qrs_lfsr.sv
// input register and parallel lfsr remainder update, one byte per cycle unless a closing byte stalls
module qrs_lfsr #(
  parameter int MAX_ECC = qrs_pkg::MAX_ECC_DEF,
  localparam int CAP = (MAX_ECC < qrs_pkg::ECC_LIMIT) ? MAX_ECC : qrs_pkg::ECC_LIMIT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_data_byte,
  input  logic                in_last_data,
  input  logic                cfg_wr_en,
  input  logic [CAP-1:0][7:0] gen_coef,
  input  logic                bank_free,
  output logic                par_load,
  output logic [CAP-1:0][7:0] par_data
);

  logic                in_vld_r;
  logic [7:0]          in_data_r;
  logic                in_last_r;
  logic [CAP-1:0][7:0] rem_r, rem_nxt, rem_upd;
  logic [CAP:0][7:0]   rem_ext;
  logic [7:0]          fb;
  logic                adv;

  // held request moves on unless it closes a block while parity is still leaving
  assign adv      = in_vld_r & (~in_last_r | bank_free);
  assign in_stall = in_vld_r & in_last_r & ~bank_free;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_data_r <= in_data_byte;
      in_last_r <= in_last_data;
    end
  end

  // one division step: shift toward entry 0 and add feedback times generator
  assign rem_ext = {8'h00, rem_r};
  assign fb      = in_data_r ^ rem_r[0];

  always_comb begin
    for (int j = 0; j < CAP; j++) begin
      rem_upd[j] = rem_ext[j+1] ^ qrs_pkg::gf_mul(gen_coef[j], fb);
    end
  end

  // remainder next value: cleared on a write and at the end of a block
  always_comb begin
    rem_nxt = rem_r;
    if (cfg_wr_en) begin
      rem_nxt = '0;
    end else if (adv) begin
      rem_nxt = in_last_r ? '0 : rem_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

  assign par_load = adv & in_last_r;
  assign par_data = rem_upd;

  // a blocked request keeps its byte
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> in_vld_r && $stable(in_data_r) && in_last_r)
    else $error("stalled input register changed");

  // the remainder starts over after each block
  assert property (@(posedge clk) disable iff (!rst_n)
    par_load |=> rem_r == '0)
    else $error("remainder not cleared after block");

endmodule

FILE: rtl/qrs_par_out.sv
// parity bank that sends the remainder out one byte per request
module qrs_par_out #(
  parameter int MAX_ECC = qrs_pkg::MAX_ECC_DEF,
  localparam int CAP   = (MAX_ECC < qrs_pkg::ECC_LIMIT) ? MAX_ECC : qrs_pkg::ECC_LIMIT,
  localparam int CNT_W = $clog2(CAP + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [CNT_W-1:0]    ecc_n,
  input  logic                par_load,
  input  logic [CAP-1:0][7:0] par_data,
  output logic                bank_free,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_parity_byte,
  output logic                out_last_parity
);

  logic [CAP-1:0][7:0] par_r;
  logic [CNT_W-1:0]    emit_cnt_r;
  logic                pop;

  assign bank_free = (emit_cnt_r == '0);
  assign out_valid = ~bank_free;
  assign pop       = out_valid & ~out_stall;

  // count of parity bytes still to go
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_cnt_r <= '0;
    end else if (par_load) begin
      emit_cnt_r <= ecc_n;
    end else if (pop) begin
      emit_cnt_r <= emit_cnt_r - CNT_W'(1);
    end
  end

  // bank shifts toward the output byte
  always_ff @(posedge clk) begin
    if (par_load) begin
      par_r <= par_data;
    end else if (pop) begin
      par_r <= {8'h00, par_r[CAP-1:1]};
    end
  end

  assign out_parity_byte = par_r[0];
  assign out_last_parity = (emit_cnt_r == CNT_W'(1));

  // a new block never overwrites parity still pending
  assert property (@(posedge clk) disable iff (!rst_n)
    par_load |-> emit_cnt_r == '0)
    else $error("parity bank overwritten");

  // a loaded block sends exactly the configured number of bytes
  assert property (@(posedge clk) disable iff (!rst_n)
    par_load |=> emit_cnt_r == $past(ecc_n))
    else $error("wrong parity count loaded");

  // after the final byte leaves the bank is empty
  assert property (@(posedge clk) disable iff (!rst_n)
    pop && out_last_parity |=> !out_valid)
    else $error("parity left after final byte");

endmodule

FILE: rtl/qr_reed_solomon_parity_encoder_unit.sv
// top level of the qr reed-solomon parity encoder over gf(256)
//
//  port group  direction  handshake           payload
//  in_*        input      in_valid/in_stall   in_data_byte[7:0], in_last_data
//  out_*       output     out_valid/out_stall out_parity_byte[7:0], out_last_parity
//  cfg_*       input      cfg_wr_en           cfg_ecc_count[4:0]
//
// one data byte per cycle unless a closing byte stalls: an input register feeds a parallel lfsr step.
// the closing byte of a block copies the remainder into the parity bank,
// which sends its n bytes while the next block streams in.
// a closing byte waits in the input register until the bank is empty.
// reset (rst_n low, synchronous) sets degree 10 (or the cap, if lower) and clears the remainder.
module qr_reed_solomon_parity_encoder_unit #(
  parameter int MAX_ECC = qrs_pkg::MAX_ECC_DEF,
  localparam int CAP   = (MAX_ECC < qrs_pkg::ECC_LIMIT) ? MAX_ECC : qrs_pkg::ECC_LIMIT,
  localparam int CNT_W = $clog2(CAP + 1)
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_parity_byte,
  output logic       out_last_parity,
  input  logic       cfg_wr_en,
  input  logic [4:0] cfg_ecc_count
);

  logic [CNT_W-1:0]    ecc_n;
  logic [CAP-1:0][7:0] gen_coef;
  logic [CAP-1:0][7:0] par_data;
  logic                par_load;
  logic                bank_free;

  // degree register and generator row
  qrs_cfg #(.MAX_ECC(MAX_ECC)) u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_ecc_count (cfg_ecc_count),
    .ecc_n         (ecc_n),
    .gen_coef      (gen_coef)
  );

  // division remainder
  qrs_lfsr #(.MAX_ECC(MAX_ECC)) u_lfsr (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_data (in_last_data),
    .cfg_wr_en    (cfg_wr_en),
    .gen_coef     (gen_coef),
    .bank_free    (bank_free),
    .par_load     (par_load),
    .par_data     (par_data)
  );

  // parity output bank
  qrs_par_out #(.MAX_ECC(MAX_ECC)) u_par_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .ecc_n           (ecc_n),
    .par_load        (par_load),
    .par_data        (par_data),
    .bank_free       (bank_free),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_parity_byte (out_parity_byte),
    .out_last_parity (out_last_parity)
  );

endmodule

FILE: sim/tb.sv
// testbench for the qr reed-solomon parity encoder: random blocks checked against a gf(256) lfsr
`timescale 1ns / 100ps

module tb;

  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 20;
  localparam int PHASES        = 7;

  // one parity codeword as it should leave the block
  typedef struct {
    logic [7:0] code;
    logic       closing;
  } parity_t;

  // lfsr division model plus the queue of parity bytes still owed
  class parity_scoreboard;
    logic [7:0]  rem [qrs_pkg::ECC_LIMIT];
    logic [7:0]  gen [qrs_pkg::ECC_LIMIT + 1];
    int unsigned deg;
    parity_t     owed_q[$];
    int          fails;

    function new();
      fails = 0;
      set_degree(5'(qrs_pkg::ECC_RESET));
    endfunction

    // gf(256) product, shifting a and reducing by the field polynomial
    function automatic logic [7:0] gf_times(logic [7:0] a, logic [7:0] b);
      logic [7:0] acc;
      logic [7:0] sh;
      acc = '0;
      sh  = a;
      for (int k = 0; k < 8; k++) begin
        if (b[k]) acc ^= sh;
        sh = {sh[6:0], 1'b0} ^ (sh[7] ? qrs_pkg::FIELD_POLY[7:0] : 8'h00);
      end
      return acc;
    endfunction

    // register write: clamp the degree, rebuild the generator, drop the partial block
    function void set_degree(logic [4:0] v);
      logic [7:0] root;
      if (v < qrs_pkg::ECC_MIN) deg = qrs_pkg::ECC_MIN;
      else if (v > qrs_pkg::ECC_LIMIT) deg = qrs_pkg::ECC_LIMIT;
      else deg = v;
      foreach (gen[j]) gen[j] = '0;
      gen[0] = 8'h01;
      root   = 8'h01;
      for (int i = 0; i < deg; i++) begin
        for (int j = i + 1; j >= 1; j--) gen[j] ^= gf_times(gen[j-1], root);
        root = gf_times(root, 8'h02);
      end
      foreach (rem[j]) rem[j] = '0;
    endfunction

    // accepted request: one lfsr step, and the whole remainder on the closing byte
    function void note_request(logic [7:0] data, logic closing);
      logic [7:0] fb;
      parity_t    p;
      fb = data ^ rem[0];
      for (int j = 0; j + 1 < deg; j++) rem[j] = rem[j+1] ^ gf_times(gen[j+1], fb);
      rem[deg-1] = gf_times(gen[deg], fb);
      if (closing) begin
        for (int j = 0; j < deg; j++) begin
          p.code    = rem[j];
          p.closing = (j + 1 == deg);
          owed_q.push_back(p);
        end
        foreach (rem[j]) rem[j] = '0;
      end
    endfunction

    function void check_parity(logic [7:0] code, logic closing);
      parity_t want;
      if (owed_q.size() == 0) begin
        $display("%0t: parity %02h last %0b with none expected", $time, code, closing);
        fails++;
        return;
      end
      want = owed_q.pop_front();
      if (code !== want.code) begin
        $display("%0t: parity_byte expected %02h actual %02h", $time, want.code, code);
        fails++;
      end
      if (closing !== want.closing) begin
        $display("%0t: last_parity expected %0b actual %0b", $time, want.closing, closing);
        fails++;
      end
    endfunction

    function int outstanding();
      return owed_q.size();
    endfunction
  endclass

  logic       clk             = 1'b0;
  logic       rst_n           = 1'b0;
  logic       in_valid        = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte    = 8'h00;
  logic       in_last_data    = 1'b0;
  logic       out_valid;
  logic       out_stall       = 1'b0;
  logic [7:0] out_parity_byte;
  logic       out_last_parity;
  logic       cfg_wr_en       = 1'b0;
  logic [4:0] cfg_ecc_count   = 5'd0;

  bit               no_gaps = 1'b0;
  parity_scoreboard sb      = new();

  qr_reed_solomon_parity_encoder_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_last_data    (in_last_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_parity_byte (out_parity_byte),
    .out_last_parity (out_last_parity),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_ecc_count   (cfg_ecc_count)
  );

  always #10 clk = ~clk;

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= !no_gaps && ($urandom_range(0, 99) < 29);
  end

  // result check
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_parity(out_parity_byte, out_last_parity);
  end

  // one request, with random idle cycles ahead of it; returns at the accepting edge
  task automatic send_item(input logic [7:0] data, input logic closing);
    @(negedge clk);
    while (!no_gaps && ($urandom_range(0, 99) < 29)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= data;
    in_last_data <= closing;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(data, closing);
  endtask

  // stop sending, let every owed parity byte drain, then give the pipeline time to empty
  task automatic go_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_degree(input logic [4:0] v);
    @(negedge clk);
    cfg_wr_en     <= 1'b1;
    cfg_ecc_count <= v;
    @(posedge clk);
    sb.set_degree(v);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int  sent;
    int  blen;
    bit  cut;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset degree: single-codeword blocks at both data extremes, then a short block
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b1);
    send_item(8'h01, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'h55, 1'b1);
    go_idle();
    // smallest degree
    load_degree(5'd2);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(8'h7F, 1'b1);
    go_idle();
    // largest degree
    load_degree(5'd30);
    send_item(8'hA5, 1'b0);
    send_item(8'h5A, 1'b1);
    go_idle();
    // degrees below the minimum and above the cap get clamped
    load_degree(5'd1);
    send_item(8'h3C, 1'b1);
    go_idle();
    load_degree(5'd0);
    send_item(8'hC3, 1'b1);
    go_idle();
    load_degree(5'd31);
    send_item(8'h01, 1'b1);
    go_idle();
    // block left open, then a register write restarts it
    load_degree(5'd5);
    send_item(8'h11, 1'b0);
    send_item(8'h22, 1'b0);
    go_idle();
    load_degree(5'd7);
    send_item(8'h33, 1'b0);
    send_item(8'h44, 1'b1);
    go_idle();
    load_degree(5'd10);
    send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b1);
    go_idle();

    // random blocks, a new degree per phase, some phases cut off mid-block
    for (int ph = 0; ph < PHASES; ph++) begin
      cut     = ($urandom_range(0, 3) == 0);
      no_gaps = (ph == 3);
      if (ph == 0) load_degree(5'd31);
      else if (ph == 1) load_degree(5'd2);
      else load_degree(5'($urandom_range(0, 31)));
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        blen = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        for (int k = 0; k < blen; k++) begin
          if (cut && sent == PHASE_ITEMS - 1) begin
            send_item(8'($urandom_range(0, 255)), 1'b0);
            sent++;
            break;
          end
          send_item(8'($urandom_range(0, 255)), k == blen - 1);
          sent++;
        end
      end
      go_idle();
    end
    no_gaps = 1'b0;

    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (sb.fails == 0 && sb.outstanding() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(4_000_000);
    $display("TEST FAILED");
    $finish;
  end

endmodule
